// ===== sv/bmw_pkg.sv =====
// bmw_pkg: shared types and constants for the 3x3 binary morphology window
// holds mode codes, register indexes, window edge masks and the scan info struct
// no dependencies

package bmw_pkg;

    // mode register codes; anything with the high bit set is hit-or-miss
    localparam logic [1:0] MODE_DILATE  = 2'd0;
    localparam logic [1:0] MODE_ERODE   = 2'd1;
    localparam logic [1:0] MODE_HITMISS = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SE_CARE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SE_VALUE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd4;

    // register reset values
    localparam logic [1:0]  RST_MODE     = MODE_DILATE;
    localparam logic [8:0]  RST_SE_CARE  = 9'h1FF;
    localparam logic [8:0]  RST_SE_VALUE = 9'h1FF;
    localparam logic [10:0] RST_WIDTH    = 11'd640;
    localparam logic [12:0] RST_HEIGHT   = 13'd480;

    localparam logic [12:0] MAX_HEIGHT = 13'd4096;

    // pixel thresholds and output levels
    localparam logic [7:0] PIX_THRESH = 8'd127;
    localparam logic [7:0] VALUE_ON   = 8'd255;
    localparam logic [7:0] VALUE_OFF  = 8'd0;

    // window positions, row-major, bit0 top-left
    localparam logic [8:0] MASK_ALL    = 9'h1FF;
    localparam logic [8:0] MASK_LEFT   = 9'h049;
    localparam logic [8:0] MASK_RIGHT  = 9'h124;
    localparam logic [8:0] MASK_TOP    = 9'h007;
    localparam logic [8:0] MASK_BOTTOM = 9'h1C0;
    localparam logic [8:0] MASK_KEEP   = 9'h0DB;

    // per-item position info from the scan counter
    typedef struct packed {
        logic        has_res;
        logic        last;
        logic        clr;
        logic [8:0]  vmask;
        logic [9:0]  col;
        logic [11:0] row;
    } scan_info_t;

endpackage

// ===== sv/bmw_line_mem.sv =====
// bmw_line_mem: two-bit wide line memory, upper and middle line bits per column
// one write port, one registered read port; no reset on the array
// no dependencies

module bmw_line_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [1:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [1:0]    wr_data
);

    logic [1:0] mem [DEPTH];
    logic [1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/bmw_scan.sv =====
// bmw_scan: input column/row counter and per-item result position info
// uses bmw_pkg for the edge masks and the scan_info_t struct

module bmw_scan #(
    parameter int unsigned AW        = 10,
    parameter int unsigned WW        = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [WW-1:0]       frame_w,
    input  logic [12:0]         frame_h,
    output logic [AW-1:0]       col_addr,
    output bmw_pkg::scan_info_t info
);

    logic [AW-1:0] col_reg, col_next;
    logic [12:0]   row_reg, row_next;
    logic [AW-1:0] cc;
    logic [12:0]   rr;
    logic [WW-1:0] cc_w, w_m1, col_inc;
    logic [12:0]   h_m1, h_p1, row_inc;
    logic          has, last, wrap;
    logic [8:0]    vmask;

    always_comb
    begin
        has  = ((col_reg != '0) && (row_reg != '0)) || (row_reg >= 13'd2);
        w_m1 = frame_w - WW'(1);
        h_m1 = frame_h - 13'd1;
        h_p1 = frame_h + 13'd1;

        // result lags one row and one column; column zero maps to the row end
        if (col_reg != '0)
        begin
            rr = row_reg - 13'd1;
            cc = col_reg - AW'(1);
        end
        else
        begin
            rr = row_reg - 13'd2;
            cc = AW'(w_m1);
        end
        cc_w = WW'(cc);

        vmask = bmw_pkg::MASK_ALL;
        if (cc == '0)
        begin
            vmask = vmask & ~bmw_pkg::MASK_LEFT;
        end
        if (cc_w >= w_m1)
        begin
            vmask = vmask & ~bmw_pkg::MASK_RIGHT;
        end
        if (rr == '0)
        begin
            vmask = vmask & ~bmw_pkg::MASK_TOP;
        end
        if (rr >= h_m1)
        begin
            vmask = vmask & ~bmw_pkg::MASK_BOTTOM;
        end

        last = has && (rr == h_m1) && (cc_w == w_m1);

        col_inc = WW'(col_reg) + WW'(1);
        row_inc = row_reg;
        wrap    = 1'b0;
        if (last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else
        begin
            if (col_inc >= frame_w)
            begin
                col_next = '0;
                row_inc  = row_reg + 13'd1;
            end
            else
            begin
                col_next = AW'(col_inc);
            end
            // ran past the drain rows: restart the frame
            if (row_inc > h_p1)
            begin
                wrap     = 1'b1;
                col_next = '0;
                row_next = '0;
            end
            else
            begin
                row_next = row_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col_addr     = col_reg;
    assign info.has_res = has;
    assign info.last    = last;
    assign info.clr     = last || wrap;
    assign info.vmask   = vmask;
    assign info.col     = 10'(cc);
    assign info.row     = 12'(rr);

endmodule

// ===== sv/bmw_match.sv =====
// bmw_match: structuring element test over a masked 3x3 bit window
// uses bmw_pkg for the mode codes

module bmw_match (
    input  logic [1:0] mode,
    input  logic [8:0] se_care,
    input  logic [8:0] se_value,
    input  logic [8:0] win,
    output logic       hit
);

    logic [8:0] elem;
    logic [8:0] refl;

    always_comb
    begin
        elem = se_care & se_value;
        // reflect through the center for dilation
        for (int k = 0; k < 9; k++)
        begin
            refl[8-k] = win[k];
        end
        case (mode)
            bmw_pkg::MODE_DILATE: hit = (refl & elem) != '0;
            bmw_pkg::MODE_ERODE:  hit = (elem & ~win) == '0;
            default:              hit = ((win ^ se_value) & se_care) == '0;
        endcase
    end

endmodule

// ===== sv/binary_morphology_window_3x3.sv =====
// binary_morphology_window_3x3: streaming 3x3 binary dilation, erosion and hit-or-miss
// depends on bmw_pkg, bmw_line_mem, bmw_scan and bmw_match
//
//   channel  | signals                                  | dir | carries
//   ---------+------------------------------------------+-----+---------------------------
//   pixel    | pixel_valid, pixel_stall, pixel, flush    | in  | one raster pixel request
//   result   | result_valid, result_stall, value, col,   | out | one result pixel request
//            | row, frame_end                            |     |
//   cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | in  | register write request
//
// one pixel request per clock unless a stalled output holds it back; a result
// passes the line memory read, then the window update into the output register
// the line memory is read and written once per request; back-to-back requests to
// the same column (one-pixel-wide frames, restarts) use a forwarding register
// reset clears the counters, window and valid flags; the line memory needs no
// clearing pass since reads of never-written columns land only on masked positions
// pixel_stall rises only while a result is stuck behind a stalled output register

module binary_morphology_window_3x3 #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              pixel_valid,
    output logic                              pixel_stall,
    input  logic [7:0]                        pixel,
    input  logic                              flush,

    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [7:0]                        value,
    output logic [9:0]                        col,
    output logic [11:0]                       row,
    output logic                              frame_end,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bmw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bmw_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
    localparam logic [12:0] MAXW13 = 13'(MAX_WIDTH);

    // configuration registers
    logic [1:0]  mode_reg;
    logic [8:0]  care_reg;
    logic [8:0]  sev_reg;
    logic [10:0] width_reg;
    logic [12:0] height_reg;

    // clamped frame size
    logic [WW-1:0] frame_w;
    logic [12:0]   frame_h;

    // scan counter
    logic [AW-1:0]       scan_col;
    bmw_pkg::scan_info_t scan_info;

    // stage 1: line memory data is back, window updates here
    logic                s1_vld_reg, s1_vld_next;
    logic [AW-1:0]       s1_addr_reg;
    logic                s1_bit_reg;
    bmw_pkg::scan_info_t s1_info_reg;
    logic                fwd_vld_reg;
    logic [1:0]          fwd_data_reg;
    logic [8:0]          win_reg, win_next;

    // output register
    logic        out_vld_reg, out_vld_next;
    logic [7:0]  out_value_reg;
    logic [9:0]  out_col_reg;
    logic [11:0] out_row_reg;
    logic        out_last_reg;

    logic       acc;
    logic       s1_go;
    logic       in_bit;
    logic [1:0] rd_data;
    logic [1:0] lines;
    logic       top_bit, mid_bit;
    logic [8:0] win_shift;
    logic [8:0] win_eff;
    logic       hit;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= bmw_pkg::RST_MODE;
            care_reg   <= bmw_pkg::RST_SE_CARE;
            sev_reg    <= bmw_pkg::RST_SE_VALUE;
            width_reg  <= bmw_pkg::RST_WIDTH;
            height_reg <= bmw_pkg::RST_HEIGHT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bmw_pkg::REG_MODE:     mode_reg   <= cfg_data[1:0];
                bmw_pkg::REG_SE_CARE:  care_reg   <= cfg_data[8:0];
                bmw_pkg::REG_SE_VALUE: sev_reg    <= cfg_data[8:0];
                bmw_pkg::REG_WIDTH:    width_reg  <= cfg_data[10:0];
                bmw_pkg::REG_HEIGHT:   height_reg <= cfg_data[12:0];
                default:               ;
            endcase
        end
    end

    // zero counts as one; width clamps to the line memory depth, height to MAX_HEIGHT
    always_comb
    begin
        if (width_reg == '0)
        begin
            frame_w = WW'(1);
        end
        else if ({2'b00, width_reg} > MAXW13)
        begin
            frame_w = WW'(MAX_WIDTH);
        end
        else
        begin
            frame_w = WW'(width_reg);
        end

        if (height_reg == '0)
        begin
            frame_h = 13'd1;
        end
        else if (height_reg > bmw_pkg::MAX_HEIGHT)
        begin
            frame_h = bmw_pkg::MAX_HEIGHT;
        end
        else
        begin
            frame_h = height_reg;
        end
    end

    // ---------------- handshake ----------------
    // stage 1 moves unless its result would land on a full, stalled output register
    assign s1_go       = s1_vld_reg &&
                         (!s1_info_reg.has_res || !out_vld_reg || !result_stall);
    assign pixel_stall = s1_vld_reg && !s1_go;
    assign acc         = pixel_valid && !pixel_stall;

    // pixel to bit: zero on flush, hit-or-miss thresholds at mid grey, others nonzero
    always_comb
    begin
        if (flush)
        begin
            in_bit = 1'b0;
        end
        else if (mode_reg[1])
        begin
            in_bit = pixel > bmw_pkg::PIX_THRESH;
        end
        else
        begin
            in_bit = pixel != '0;
        end
    end

    // ---------------- stage 0: scan position and line memory read ----------------
    bmw_scan #(
        .AW        (AW),
        .WW        (WW)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (acc),
        .frame_w  (frame_w),
        .frame_h  (frame_h),
        .col_addr (scan_col),
        .info     (scan_info)
    );

    // entry is {upper, middle}; the column shifts middle into upper and the new bit
    // into middle
    bmw_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (acc),
        .rd_addr (scan_col),
        .rd_data (rd_data),
        .wr_en   (s1_go),
        .wr_addr (s1_addr_reg),
        .wr_data ({mid_bit, s1_bit_reg})
    );

    // ---------------- stage 1: window update and decision ----------------
    assign lines   = fwd_vld_reg ? fwd_data_reg : rd_data;
    assign top_bit = lines[1];
    assign mid_bit = lines[0];

    // window shifts left by one column; new column enters at the right edge
    assign win_shift = ((win_reg >> 1) & bmw_pkg::MASK_KEEP) |
                       {s1_bit_reg, 2'b00, mid_bit, 2'b00, top_bit, 2'b00};
    assign win_eff   = win_shift & s1_info_reg.vmask;

    bmw_match u_match (
        .mode     (mode_reg),
        .se_care  (care_reg),
        .se_value (sev_reg),
        .win      (win_eff),
        .hit      (hit)
    );

    always_comb
    begin
        s1_vld_next = acc ? 1'b1 : (s1_go ? 1'b0 : s1_vld_reg);

        win_next = win_reg;
        if (s1_go)
        begin
            // frame end or wrap restarts the window after this result
            win_next = s1_info_reg.clr ? '0 : win_shift;
        end

        out_vld_next = out_vld_reg && result_stall;
        if (s1_go && s1_info_reg.has_res)
        begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            fwd_vld_reg <= 1'b0;
            win_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            win_reg     <= win_next;
            out_vld_reg <= out_vld_next;
            if (acc)
            begin
                // same column written back this cycle: memory data would be stale
                fwd_vld_reg <= s1_go && (s1_addr_reg == scan_col);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_addr_reg  <= scan_col;
            s1_bit_reg   <= in_bit;
            s1_info_reg  <= scan_info;
            fwd_data_reg <= {mid_bit, s1_bit_reg};
        end
        if (s1_go && s1_info_reg.has_res)
        begin
            out_value_reg <= hit ? bmw_pkg::VALUE_ON : bmw_pkg::VALUE_OFF;
            out_col_reg   <= s1_info_reg.col;
            out_row_reg   <= s1_info_reg.row;
            out_last_reg  <= s1_info_reg.last;
        end
    end

    assign result_valid = out_vld_reg;
    assign value        = out_value_reg;
    assign col          = out_col_reg;
    assign row          = out_row_reg;
    assign frame_end    = out_last_reg;

endmodule

// ===== tb/sv/bmw_checker.sv =====
`timescale 1ns / 100ps
// bmw_checker: predicts each result of the 3x3 binary morphology window and compares it
// watches the pixel, result and register write channels; depends on bmw_pkg

module bmw_checker #(
    parameter int unsigned LINE_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              pixel_valid,
    input  logic                              pixel_stall,
    input  logic [7:0]                        pixel,
    input  logic                              flush,

    input  logic                              result_valid,
    input  logic                              result_stall,
    input  logic [7:0]                        value,
    input  logic [9:0]                        col,
    input  logic [11:0]                       row,
    input  logic                              frame_end,

    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [bmw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bmw_pkg::CFG_DATA_W-1:0]    cfg_data,

    output int                                mismatches,
    output int                                outstanding,
    output int                                checked
);

    localparam int REPORT_CAP = 60;

    typedef struct packed {
        logic [7:0]  value;
        logic [9:0]  col;
        logic [11:0] row;
        logic        frame_end;
    } morph_result_t;

    // register copies
    logic [1:0]  mode_q;
    logic [8:0]  care_q;
    logic [8:0]  match_q;
    logic [10:0] width_q;
    logic [12:0] height_q;

    // scan state
    bit          upper_line [LINE_DEPTH];
    bit          middle_line [LINE_DEPTH];
    logic [8:0]  window_q;
    int unsigned scan_col;
    int unsigned scan_row;

    morph_result_t expected_q [$];

    function automatic logic [8:0] mirror_window(input logic [8:0] bits);
        logic [8:0] flipped;
        flipped = '0;
        for (int k = 0; k < 9; k++)
            flipped[8-k] = bits[k];
        return flipped;
    endfunction

    // one pixel request: shift the window, and queue the result it completes
    task automatic advance_window(input logic [7:0] pix, input logic pad);
        int unsigned   w;
        int unsigned   h;
        int unsigned   c;
        int unsigned   r;
        int unsigned   rr;
        int unsigned   cc;
        logic [8:0]    border;
        logic [8:0]    seen;
        logic [8:0]    elem;
        logic          bit_in;
        logic          top_bit;
        logic          mid_bit;
        logic          hit;
        logic          is_last;
        morph_result_t res;

        w = (width_q == 0) ? 1 : (width_q > LINE_DEPTH) ? LINE_DEPTH : width_q;
        h = (height_q == 0) ? 1 :
            (height_q > bmw_pkg::MAX_HEIGHT) ? bmw_pkg::MAX_HEIGHT : height_q;
        c = scan_col;
        r = scan_row;

        if (pad)
            bit_in = 1'b0;
        else if ((mode_q & bmw_pkg::MODE_HITMISS) != 0)
            bit_in = (pix > bmw_pkg::PIX_THRESH);
        else
            bit_in = (pix != 0);

        top_bit = 1'b0;
        mid_bit = 1'b0;
        if (c < LINE_DEPTH)
        begin
            top_bit = upper_line[c];
            mid_bit = middle_line[c];
            upper_line[c] = mid_bit;
            middle_line[c] = bit_in;
        end
        window_q = ((window_q >> 1) & bmw_pkg::MASK_KEEP) |
                   {bit_in, 2'b00, mid_bit, 2'b00, top_bit, 2'b00};

        if ((c >= 1 && r >= 1) || r >= 2)
        begin
            if (c >= 1)
            begin
                rr = r - 1;
                cc = c - 1;
            end
            else
            begin
                rr = r - 2;
                cc = w - 1;
            end
            border = bmw_pkg::MASK_ALL;
            if (cc == 0)
                border &= ~bmw_pkg::MASK_LEFT;
            if (cc >= w - 1)
                border &= ~bmw_pkg::MASK_RIGHT;
            if (rr == 0)
                border &= ~bmw_pkg::MASK_TOP;
            if (rr >= h - 1)
                border &= ~bmw_pkg::MASK_BOTTOM;
            seen = window_q & border;
            elem = care_q & match_q;

            if ((mode_q & bmw_pkg::MODE_HITMISS) != 0)
                hit = (((seen ^ match_q) & care_q) == 0);
            else if (mode_q == bmw_pkg::MODE_ERODE)
                hit = ((elem & ~seen) == 0);
            else
                hit = ((mirror_window(seen) & elem) != 0);

            is_last = (rr == h - 1) && (cc == w - 1);
            res.value = hit ? bmw_pkg::VALUE_ON : bmw_pkg::VALUE_OFF;
            res.col = cc[9:0];
            res.row = rr[11:0];
            res.frame_end = is_last;
            expected_q.insert(expected_q.size(), res);

            if (is_last)
            begin
                scan_col = 0;
                scan_row = 0;
                window_q = '0;
                return;
            end
        end

        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        // ran past the drain rows: restart the scan
        if (r > h + 1)
        begin
            c = 0;
            r = 0;
            window_q = '0;
        end
        scan_col = c;
        scan_row = r;
    endtask

    task automatic compare_field(input string field, input logic [11:0] want,
                                 input logic [11:0] got);
        if (got !== want)
        begin
            if (mismatches < REPORT_CAP)
                $error("%s mismatch on result %0d: expected %0d, actual %0d",
                       field, checked, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        morph_result_t want;
        if (!rst_n)
        begin
            mode_q = bmw_pkg::RST_MODE;
            care_q = bmw_pkg::RST_SE_CARE;
            match_q = bmw_pkg::RST_SE_VALUE;
            width_q = bmw_pkg::RST_WIDTH;
            height_q = bmw_pkg::RST_HEIGHT;
            window_q = '0;
            scan_col = 0;
            scan_row = 0;
            expected_q.delete();
            outstanding <= 0;
        end
        else
        begin
            // retire first so a result never meets an expectation queued this edge
            if (result_valid && !result_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    if (mismatches < REPORT_CAP)
                        $error("result request at col %0d row %0d with no expectation waiting",
                               col, row);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("value", 12'(want.value), 12'(value));
                    compare_field("col", 12'(want.col), 12'(col));
                    compare_field("row", want.row, row);
                    compare_field("frame_end", 12'(want.frame_end), 12'(frame_end));
                end
                checked++;
            end

            if (pixel_valid && !pixel_stall)
                advance_window(pixel, flush);

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bmw_pkg::REG_MODE:     mode_q = cfg_data[1:0];
                    bmw_pkg::REG_SE_CARE:  care_q = cfg_data[8:0];
                    bmw_pkg::REG_SE_VALUE: match_q = cfg_data[8:0];
                    bmw_pkg::REG_WIDTH:    width_q = cfg_data[10:0];
                    bmw_pkg::REG_HEIGHT:   height_q = cfg_data[12:0];
                    default:               ;
                endcase
            end

            outstanding <= expected_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for binary_morphology_window_3x3
// instantiates the block and bmw_checker side by side; depends on bmw_pkg

module tb_top;

    localparam int unsigned MAX_COLS     = 1024;
    localparam int unsigned ITEM_TARGET  = 1850;
    // output register plus line memory read, with margin
    localparam int unsigned DRAIN_CYCLES = 8;
    // worst case: ~2k requests, each behind the longest idle gap and stall, times 5
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;

    logic                            pixel_valid = 1'b0;
    logic                            pixel_stall;
    logic [7:0]                      pixel = '0;
    logic                            flush = 1'b0;

    logic                            result_valid;
    logic                            result_stall = 1'b0;
    logic [7:0]                      value;
    logic [9:0]                      col;
    logic [11:0]                     row;
    logic                            frame_end;

    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [bmw_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [bmw_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    int                              mismatches;
    int                              outstanding;
    int                              checked;

    // stimulus bookkeeping
    int unsigned                     pixels_sent = 0;
    int unsigned                     frames = 0;
    int unsigned                     cycle_count = 0;
    int unsigned                     fill = 50;
    bit                              sender_calm = 1'b0;
    logic [1:0]                      mode_reg = bmw_pkg::RST_MODE;

    // receiver stall state
    int unsigned                     stall_left = 0;
    int unsigned                     open_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    binary_morphology_window_3x3 #(
        .MAX_WIDTH (MAX_COLS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .flush        (flush),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value),
        .col          (col),
        .row          (row),
        .frame_end    (frame_end),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    bmw_checker #(
        .LINE_DEPTH (MAX_COLS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .flush        (flush),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value),
        .col          (col),
        .row          (row),
        .frame_end    (frame_end),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .checked      (checked)
    );

    // mostly short idle runs, now and then a long one
    function automatic int unsigned idle_cycles();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // frame size as the block sees it: zero counts as one, large values clamp
    function automatic int unsigned active_size(input int unsigned setting,
                                                input int unsigned ceiling);
        if (setting == 0)
            return 1;
        if (setting > ceiling)
            return ceiling;
        return setting;
    endfunction

    // structuring element shapes: full, plus, sparse, empty or random
    function automatic logic [8:0] se_pattern();
        case ($urandom_range(0, 5))
            0:       return bmw_pkg::MASK_ALL;
            1:       return 9'h0BA;
            2:       return 9'($urandom_range(0, 511) & $urandom_range(0, 511)
                               & $urandom_range(0, 511));
            3:       return '0;
            default: return 9'($urandom_range(0, 511));
        endcase
    endfunction

    // grey value mostly on the set or clear side of the current mode's threshold
    function automatic logic [7:0] next_pixel();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return 8'($urandom_range(0, 255));
        if (pick < 8 + fill)
            return ((mode_reg & bmw_pkg::MODE_HITMISS) != 0) ? 8'($urandom_range(128, 255))
                                                              : 8'($urandom_range(1, 255));
        return ((mode_reg & bmw_pkg::MODE_HITMISS) != 0) ? 8'($urandom_range(0, 127)) : 8'd0;
    endfunction

    // leaves cfg_valid high so back-to-back writes never drop and raise it in one step
    task automatic write_reg(input logic [bmw_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[bmw_pkg::CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        if (idx == bmw_pkg::REG_MODE)
            mode_reg = data[1:0];
    endtask

    // optional idle gap, then one pixel request held until taken
    task automatic send_pixel(input logic [7:0] pix, input logic pad);
        int unsigned gap;
        gap = sender_calm ? 0 : idle_cycles();
        if (gap != 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= pix;
        flush       <= pad;
        do @(posedge clk); while (pixel_stall);
        pixels_sent++;
    endtask

    // stop sending until every expected result is back, then let the pipe empty
    task automatic settle();
        pixel_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one raster frame plus its width+1 drain requests
    // pause_at >= 0 stops mid-frame there and changes mode or element
    task automatic run_frame(input int unsigned w, input int unsigned h, input int pause_at);
        int unsigned r;
        int unsigned c;
        int unsigned k;
        int          n;
        n = 0;
        for (r = 0; r < h; r++)
        begin
            for (c = 0; c < w; c++)
            begin
                if (n == pause_at)
                begin
                    settle();
                    case ($urandom_range(0, 2))
                        0:       write_reg(bmw_pkg::REG_MODE, $urandom_range(0, 3));
                        1:       write_reg(bmw_pkg::REG_SE_CARE, se_pattern());
                        default: write_reg(bmw_pkg::REG_SE_VALUE, se_pattern());
                    endcase
                    cfg_valid <= 1'b0;
                end
                // a stray flush inside the image now and then
                if ($urandom_range(0, 99) < 2)
                    send_pixel(8'($urandom_range(0, 255)), 1'b1);
                else
                    send_pixel(next_pixel(), 1'b0);
                n++;
            end
        end
        // drain requests, with the odd one sent as a plain pixel
        for (k = 0; k <= w; k++)
            send_pixel(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 97);
        frames++;
    endtask

    // receiver: random stall bursts between open stretches, some of them long
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
            open_left = 0;
        end
        else if (stall_left != 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else if (open_left != 0)
        begin
            result_stall <= 1'b0;
            open_left--;
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            result_stall <= 1'b1;
            stall_left = idle_cycles();
        end
        else
        begin
            result_stall <= 1'b0;
            open_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(0, 8);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int unsigned w_set;
        int unsigned h_set;
        int unsigned w;
        int unsigned h;
        int unsigned random_start;
        int unsigned k;
        int          pause_at;
        bit          room;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----

        // single-pixel frame, dilation with the full element; the second drain request
        // carries a set pixel value that must be ignored
        write_reg(bmw_pkg::REG_WIDTH, 1);
        write_reg(bmw_pkg::REG_HEIGHT, 1);
        write_reg(bmw_pkg::REG_MODE, bmw_pkg::MODE_DILATE);
        cfg_valid <= 1'b0;
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b1);
        frames++;
        settle();

        // 2x2 erosion with a centre-only element: result follows each pixel bit,
        // including the smallest nonzero value
        write_reg(bmw_pkg::REG_MODE, bmw_pkg::MODE_ERODE);
        write_reg(bmw_pkg::REG_SE_CARE, 9'h010);
        write_reg(bmw_pkg::REG_SE_VALUE, bmw_pkg::MASK_ALL);
        write_reg(bmw_pkg::REG_WIDTH, 2);
        write_reg(bmw_pkg::REG_HEIGHT, 2);
        cfg_valid <= 1'b0;
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd128, 1'b0);
        for (k = 0; k < 3; k++)
            send_pixel(8'd0, 1'b1);
        frames++;
        settle();

        // unused mode code behaves as hit-or-miss; pixels straddle the 127/128
        // threshold against a middle-row pattern
        write_reg(bmw_pkg::REG_MODE, bmw_pkg::MODE_HITMISS | bmw_pkg::MODE_ERODE);
        write_reg(bmw_pkg::REG_SE_CARE, bmw_pkg::MASK_ALL);
        write_reg(bmw_pkg::REG_SE_VALUE, 9'h038);
        write_reg(bmw_pkg::REG_WIDTH, 3);
        write_reg(bmw_pkg::REG_HEIGHT, 1);
        cfg_valid <= 1'b0;
        send_pixel(8'd127, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd255, 1'b0);
        for (k = 0; k < 4; k++)
            send_pixel(8'd127, 1'b1);
        frames++;
        settle();

        // zero width and height count as one; no cared positions always hits
        write_reg(bmw_pkg::REG_MODE, bmw_pkg::MODE_HITMISS);
        write_reg(bmw_pkg::REG_SE_CARE, 0);
        write_reg(bmw_pkg::REG_WIDTH, 0);
        write_reg(bmw_pkg::REG_HEIGHT, 0);
        cfg_valid <= 1'b0;
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd0, 1'b1);
        frames++;
        settle();

        // ---- random part: mostly small frames, a larger one while there is room ----
        random_start = pixels_sent;
        while (pixels_sent - random_start < ITEM_TARGET)
        begin
            sender_calm = ($urandom_range(0, 4) == 0);
            fill = $urandom_range(5, 85);
            pause_at = -1;
            room = (pixels_sent - random_start + 900 < ITEM_TARGET);

            if ($urandom_range(0, 9) < 6)
                write_reg(bmw_pkg::REG_MODE, $urandom_range(0, 3));
            if ($urandom_range(0, 9) < 6)
                write_reg(bmw_pkg::REG_SE_CARE, se_pattern());
            if ($urandom_range(0, 9) < 6)
                write_reg(bmw_pkg::REG_SE_VALUE, se_pattern());

            if (frames == 17)
            begin
                w_set = $urandom_range(2, 6);
                h_set = 6;
            end
            else
            begin
                w_set = (room && $urandom_range(0, 6) == 0) ? $urandom_range(13, 40)
                                                             : $urandom_range(1, 12);
                h_set = (room && $urandom_range(0, 6) == 0) ? $urandom_range(9, 20)
                                                             : $urandom_range(1, 8);
            end
            write_reg(bmw_pkg::REG_WIDTH, w_set);
            write_reg(bmw_pkg::REG_HEIGHT, h_set);
            cfg_valid <= 1'b0;

            w = active_size(w_set, MAX_COLS);
            h = active_size(h_set, bmw_pkg::MAX_HEIGHT);

            if (frames == 17)
            begin
                // three rows in, shrink the height so the scan runs past the
                // drain rows and restarts on the next request
                for (k = 0; k < 3 * w; k++)
                    send_pixel(next_pixel(), 1'b0);
                settle();
                write_reg(bmw_pkg::REG_HEIGHT, 1);
                cfg_valid <= 1'b0;
                send_pixel(next_pixel(), 1'b0);
                frames++;
            end
            else
            begin
                // every few frames, change mode or element part way through
                if (frames % 4 == 1 && w * h > 1)
                    pause_at = $urandom_range(1, w * h - 1);
                run_frame(w, h, pause_at);
            end
            settle();
        end

        settle();
        $display("run summary: %0d frames, %0d pixel requests sent, %0d result requests checked",
                 frames, pixels_sent, checked);
        $display("run summary: all three modes and the spare code, zero sizes counted as one, "
                 , "mid-frame register changes and a scan restart");
        if (mismatches == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
